[design/three_level_feedback_scheduler_assert.svh]
// assertion macros for the three-level feedback scheduler
`ifndef THREE_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`define THREE_LEVEL_FEEDBACK_SCHEDULER_ASSERT_SVH
`ifndef SYNTHESIS
// clocked check, masked while reset is asserted
`define TLFS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked check that also holds through reset
`define TLFS_ASSERT_NORST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TLFS_ASSERT(lbl, clk, rstn, prop, msg)
`define TLFS_ASSERT_NORST(lbl, clk, prop, msg)
`endif
`endif

[design/tlfs_pkg.sv]
// shared types and constants of the three-level feedback scheduler
`default_nettype none
package tlfs_pkg;
    typedef logic [1:0] level_t;

    localparam int     NUM_LEVELS = 3;
    localparam level_t LVL_TOP    = 2'd0;
    localparam level_t LVL_MID    = 2'd1;
    localparam level_t LVL_LOW    = 2'd2;

    localparam logic KIND_ARRIVAL = 1'b0;
    localparam logic KIND_TICK    = 1'b1;

    // register map
    localparam int         CFG_ADDR_W       = 4;
    localparam logic [1:0] REG_QUANTUM_TOP  = 2'd0;
    localparam logic [1:0] REG_QUANTUM_MID  = 2'd1;
    localparam logic [1:0] REG_QUANTUM_LOW  = 2'd2;
    localparam logic [1:0] REG_STARVE_LIMIT = 2'd3;

    localparam logic [15:0] QUANTUM_TOP_RST  = 16'd2;
    localparam logic [15:0] QUANTUM_MID_RST  = 16'd4;
    localparam logic [15:0] QUANTUM_LOW_RST  = 16'd8;
    localparam logic [15:0] STARVE_LIMIT_RST = 16'd100;
    localparam logic [15:0] RUN_SAT          = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [5:0]  job_id;
        logic [15:0] burst_length;
        logic [1:0]  priority_req;
    } in_word_t;

    typedef struct packed {
        logic        busy_res;
        logic [5:0]  ran_job;
        logic [1:0]  ran_level;
        logic        job_done;
        logic [31:0] turnaround_time;
        logic [31:0] response_time;
        logic [31:0] wait_time;
    } out_word_t;
endpackage
`default_nettype wire

[design/three_level_feedback_scheduler.sv]
// three-level feedback job scheduler with a walking sequencer over job memory
//
//  channel | ports                                  | word
//  --------+----------------------------------------+-------------------------
//  input   | s_valid s_ready s_data                 | arrival or tick
//  result  | m_valid m_ready m_data                 | one per tick
//  config  | psel penable pwrite paddr pwdata prdata| four 16-bit registers
//
// an arrival is taken in idle; a tick steps through preemption, the starvation checks, a
// boost that lifts starved jobs one at a time, dispatch, an ageing walk over every job
// waiting in queues and one run unit before its result; an idle tick goes from dispatch
// straight to the result, all in sequence over the single port on the job memory.
// reset is synchronous and clears control state; job memory is written on arrival.
// a finished result holds in its register until taken; no word is taken meanwhile.
`default_nettype none
`include "three_level_feedback_scheduler_assert.svh"
module three_level_feedback_scheduler #(
    parameter int MAX_JOBS   = 64,
    parameter int TIME_WIDTH = 32
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire tlfs_pkg::in_word_t              s_data,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output tlfs_pkg::out_word_t                  m_data,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [tlfs_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [31:0]                     pwdata,
    output logic [31:0]                          prdata,
    output logic                                 pready
);
    import tlfs_pkg::*;

    localparam int JW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CW = $clog2(MAX_JOBS + 1);
    localparam int TW = TIME_WIDTH;

    typedef logic [JW-1:0] jidx_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [TW-1:0] tval_t;

    typedef struct packed {
        level_t      level;
        logic [15:0] remaining;
        logic [15:0] level_run;
        tval_t       arrival;
        tval_t       start_stamp;
        logic        started;
        tval_t       wait_sum;
        tval_t       wait_tail;
    } job_rec_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_PRE, ST_SRD1, ST_SCHK1, ST_SCHK2, ST_LRD, ST_LWR, ST_DSP,
        ST_POP, ST_AINIT, ST_ARD, ST_AWR, ST_RRD, ST_RWR, ST_OUT
    } state_t;

    state_t      state_reg;
    logic [15:0] qtop_reg, qmid_reg, qlow_reg, starve_reg;
    tval_t       time_reg;
    logic        run_valid_reg;
    jidx_t       run_job_reg;
    level_t      run_lv_reg;
    logic        ftop_reg, fmid_reg;
    jidx_t       head_reg [NUM_LEVELS];
    jidx_t       tail_reg [NUM_LEVELS];
    cnt_t        cnt_reg  [NUM_LEVELS];
    logic        active_reg [MAX_JOBS];
    jidx_t       cur_reg;
    level_t      lift_lv_reg, dsp_lv_reg, age_lv_reg;
    logic        lift_both_reg;
    cnt_t        age_n_reg;
    out_word_t   res_reg;

    // job memory and link memory
    job_rec_t    job_mem  [MAX_JOBS];
    jidx_t       link_mem [MAX_JOBS];
    job_rec_t    job_rd_reg;
    jidx_t       link_rd_reg;

    logic        job_we, link_we;
    jidx_t       job_wa, link_wa, link_wd, rd_addr;
    job_rec_t    job_wd;

    logic        arr_ok, pre_go, starve_hit, dsp_found;
    jidx_t       arr_idx;
    level_t      arr_lv, dsp_sel, next_lv;
    tval_t       time_inc, first_val, tat_val, rsp_val;
    logic [15:0] rem_val, run_val, quant_val;
    logic        done_val, demote_val;

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = (state_reg == ST_OUT);
    assign m_data  = res_reg;
    assign pready  = 1'b1;

    // register read-back
    always_comb begin
        unique case (paddr[3:2])
            REG_QUANTUM_TOP:  prdata = 32'(qtop_reg);
            REG_QUANTUM_MID:  prdata = 32'(qmid_reg);
            REG_QUANTUM_LOW:  prdata = 32'(qlow_reg);
            REG_STARVE_LIMIT: prdata = 32'(starve_reg);
            default:          prdata = '0;
        endcase
    end

    // arrival decode
    assign arr_idx = jidx_t'(s_data.job_id);
    assign arr_lv  = (s_data.priority_req == 2'd3) ? LVL_LOW : s_data.priority_req;
    assign arr_ok  = (state_reg == ST_IDLE) && s_valid && (s_data.kind == KIND_ARRIVAL)
                     && (int'(s_data.job_id) < MAX_JOBS) && !active_reg[arr_idx];

    // preemption by fresh arrivals of a higher level
    assign pre_go = run_valid_reg &&
                    (((run_lv_reg == LVL_LOW) && (ftop_reg || fmid_reg)) ||
                     ((run_lv_reg == LVL_MID) && ftop_reg));

    assign starve_hit = (job_rd_reg.wait_tail >= TW'(starve_reg));

    // highest nonempty queue
    always_comb begin
        dsp_found = 1'b1;
        if (cnt_reg[LVL_TOP] != '0) begin
            dsp_sel = LVL_TOP;
        end else if (cnt_reg[LVL_MID] != '0) begin
            dsp_sel = LVL_MID;
        end else begin
            dsp_sel   = LVL_LOW;
            dsp_found = (cnt_reg[LVL_LOW] != '0);
        end
    end

    // one unit of run for the current job
    always_comb begin
        time_inc   = time_reg + 1'b1;
        first_val  = job_rd_reg.started ? job_rd_reg.start_stamp : time_reg;
        rem_val    = job_rd_reg.remaining - 1'b1;
        run_val    = (job_rd_reg.level_run == RUN_SAT) ? RUN_SAT
                                                       : job_rd_reg.level_run + 1'b1;
        done_val   = (rem_val == '0);
        case (run_lv_reg)
            LVL_TOP: quant_val = qtop_reg;
            LVL_MID: quant_val = qmid_reg;
            default: quant_val = qlow_reg;
        endcase
        next_lv    = (run_lv_reg == LVL_TOP) ? LVL_MID : LVL_LOW;
        demote_val = !done_val && (run_val >= quant_val);
        tat_val    = time_inc - job_rd_reg.arrival;
        rsp_val    = first_val - job_rd_reg.arrival;
    end

    // memory read address per step
    always_comb begin
        case (state_reg)
            ST_SRD1:  rd_addr = head_reg[LVL_MID];
            ST_SCHK1: rd_addr = head_reg[LVL_LOW];
            ST_LRD:   rd_addr = head_reg[lift_lv_reg];
            ST_DSP:   rd_addr = head_reg[dsp_sel];
            ST_ARD:   rd_addr = cur_reg;
            ST_RRD:   rd_addr = run_job_reg;
            default:  rd_addr = '0;
        endcase
    end

    // memory write port per step
    always_comb begin
        job_we  = 1'b0;
        job_wa  = cur_reg;
        job_wd  = job_rd_reg;
        link_we = 1'b0;
        link_wa = cur_reg;
        link_wd = cur_reg;
        case (state_reg)
            ST_IDLE: begin
                job_we              = arr_ok;
                job_wa              = arr_idx;
                job_wd.level        = arr_lv;
                job_wd.remaining    = (s_data.burst_length == '0) ? 16'd1
                                                                  : s_data.burst_length;
                job_wd.level_run    = '0;
                job_wd.arrival      = time_reg;
                job_wd.start_stamp  = '0;
                job_wd.started      = 1'b0;
                job_wd.wait_sum     = '0;
                job_wd.wait_tail    = '0;
                link_we             = arr_ok && (cnt_reg[arr_lv] != '0);
                link_wa             = tail_reg[arr_lv];
                link_wd             = arr_idx;
            end
            ST_PRE: begin
                link_we = pre_go && (cnt_reg[run_lv_reg] != '0);
                link_wa = run_job_reg;
                link_wd = head_reg[run_lv_reg];
            end
            ST_LWR: begin
                job_we           = 1'b1;
                job_wd.level     = LVL_TOP;
                job_wd.level_run = '0;
                job_wd.wait_tail = '0;
                link_we          = (cnt_reg[LVL_TOP] != '0);
                link_wa          = tail_reg[LVL_TOP];
            end
            ST_AWR: begin
                job_we          = 1'b1;
                job_wd.wait_sum = job_rd_reg.wait_sum + 1'b1;
                if (job_rd_reg.wait_tail != '1) begin
                    job_wd.wait_tail = job_rd_reg.wait_tail + 1'b1;
                end
            end
            ST_RWR: begin
                job_we             = 1'b1;
                job_wa             = run_job_reg;
                job_wd.started     = 1'b1;
                job_wd.start_stamp = first_val;
                job_wd.remaining   = rem_val;
                job_wd.level_run   = demote_val ? 16'd0 : run_val;
                if (demote_val) begin
                    job_wd.level     = next_lv;
                    job_wd.wait_tail = '0;
                end
                link_we = demote_val && (cnt_reg[next_lv] != '0);
                link_wa = tail_reg[next_lv];
                link_wd = run_job_reg;
            end
            default: ;
        endcase
    end

    // memories, registered reads
    always_ff @(posedge aclk) begin
        if (job_we) begin
            job_mem[job_wa] <= job_wd;
        end
        if (link_we) begin
            link_mem[link_wa] <= link_wd;
        end
        job_rd_reg  <= job_mem[rd_addr];
        link_rd_reg <= link_mem[rd_addr];
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            qtop_reg      <= QUANTUM_TOP_RST;
            qmid_reg      <= QUANTUM_MID_RST;
            qlow_reg      <= QUANTUM_LOW_RST;
            starve_reg    <= STARVE_LIMIT_RST;
            time_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_job_reg   <= '0;
            run_lv_reg    <= LVL_TOP;
            ftop_reg      <= 1'b0;
            fmid_reg      <= 1'b0;
            lift_both_reg <= 1'b0;
            for (int i = 0; i < NUM_LEVELS; i++) begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
                cnt_reg[i]  <= '0;
            end
            for (int i = 0; i < MAX_JOBS; i++) begin
                active_reg[i] <= 1'b0;
            end
        end else begin
            // configuration writes
            if (psel && penable && pwrite) begin
                unique case (paddr[3:2])
                    REG_QUANTUM_TOP:  qtop_reg   <= pwdata[15:0];
                    REG_QUANTUM_MID:  qmid_reg   <= pwdata[15:0];
                    REG_QUANTUM_LOW:  qlow_reg   <= pwdata[15:0];
                    REG_STARVE_LIMIT: starve_reg <= pwdata[15:0];
                    default: ;
                endcase
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid && (s_data.kind == KIND_TICK)) begin
                        state_reg <= ST_PRE;
                    end else if (arr_ok) begin
                        active_reg[arr_idx] <= 1'b1;
                        if (cnt_reg[arr_lv] == '0) begin
                            head_reg[arr_lv] <= arr_idx;
                        end
                        tail_reg[arr_lv] <= arr_idx;
                        cnt_reg[arr_lv]  <= cnt_reg[arr_lv] + 1'b1;
                        if (arr_lv == LVL_TOP) begin
                            ftop_reg <= 1'b1;
                        end else if (arr_lv == LVL_MID) begin
                            fmid_reg <= 1'b1;
                        end
                    end
                end
                ST_PRE: begin
                    if (pre_go) begin
                        if (cnt_reg[run_lv_reg] == '0) begin
                            tail_reg[run_lv_reg] <= run_job_reg;
                        end
                        head_reg[run_lv_reg] <= run_job_reg;
                        cnt_reg[run_lv_reg]  <= cnt_reg[run_lv_reg] + 1'b1;
                        run_valid_reg        <= 1'b0;
                    end
                    ftop_reg  <= 1'b0;
                    fmid_reg  <= 1'b0;
                    state_reg <= ST_SRD1;
                end
                ST_SRD1: state_reg <= ST_SCHK1;
                // starvation check on the middle and low queue heads
                ST_SCHK1: begin
                    if ((cnt_reg[LVL_MID] != '0) && starve_hit) begin
                        lift_lv_reg   <= LVL_MID;
                        lift_both_reg <= 1'b1;
                        state_reg     <= ST_LRD;
                    end else begin
                        state_reg <= ST_SCHK2;
                    end
                end
                ST_SCHK2: begin
                    if ((cnt_reg[LVL_LOW] != '0) && starve_hit) begin
                        lift_lv_reg   <= LVL_LOW;
                        lift_both_reg <= 1'b0;
                        state_reg     <= ST_LRD;
                    end else begin
                        state_reg <= ST_DSP;
                    end
                end
                // boost: move queue entries one at a time to the top tail
                ST_LRD: begin
                    if (cnt_reg[lift_lv_reg] == '0) begin
                        if (lift_both_reg && (lift_lv_reg == LVL_MID)) begin
                            lift_lv_reg <= LVL_LOW;
                        end else begin
                            state_reg <= ST_DSP;
                        end
                    end else begin
                        cur_reg   <= head_reg[lift_lv_reg];
                        state_reg <= ST_LWR;
                    end
                end
                ST_LWR: begin
                    head_reg[lift_lv_reg] <= link_rd_reg;
                    cnt_reg[lift_lv_reg]  <= cnt_reg[lift_lv_reg] - 1'b1;
                    if (cnt_reg[LVL_TOP] == '0) begin
                        head_reg[LVL_TOP] <= cur_reg;
                    end
                    tail_reg[LVL_TOP] <= cur_reg;
                    cnt_reg[LVL_TOP]  <= cnt_reg[LVL_TOP] + 1'b1;
                    state_reg         <= ST_LRD;
                end
                // dispatch
                ST_DSP: begin
                    if (run_valid_reg) begin
                        age_lv_reg <= LVL_TOP;
                        state_reg  <= ST_AINIT;
                    end else if (dsp_found) begin
                        cur_reg    <= head_reg[dsp_sel];
                        dsp_lv_reg <= dsp_sel;
                        state_reg  <= ST_POP;
                    end else begin
                        res_reg   <= '0;
                        time_reg  <= time_inc;
                        state_reg <= ST_OUT;
                    end
                end
                ST_POP: begin
                    head_reg[dsp_lv_reg] <= link_rd_reg;
                    cnt_reg[dsp_lv_reg]  <= cnt_reg[dsp_lv_reg] - 1'b1;
                    run_job_reg          <= cur_reg;
                    run_valid_reg        <= 1'b1;
                    run_lv_reg           <= dsp_lv_reg;
                    age_lv_reg           <= LVL_TOP;
                    state_reg            <= ST_AINIT;
                end
                // ageing walk over every queue
                ST_AINIT: begin
                    cur_reg   <= head_reg[age_lv_reg];
                    age_n_reg <= cnt_reg[age_lv_reg];
                    state_reg <= ST_ARD;
                end
                ST_ARD: begin
                    if (age_n_reg == '0) begin
                        if (age_lv_reg == LVL_LOW) begin
                            state_reg <= ST_RRD;
                        end else begin
                            age_lv_reg <= age_lv_reg + 1'b1;
                            state_reg  <= ST_AINIT;
                        end
                    end else begin
                        state_reg <= ST_AWR;
                    end
                end
                ST_AWR: begin
                    cur_reg   <= link_rd_reg;
                    age_n_reg <= age_n_reg - 1'b1;
                    state_reg <= ST_ARD;
                end
                ST_RRD: state_reg <= ST_RWR;
                // run one unit, then complete, demote or keep running
                ST_RWR: begin
                    time_reg                <= time_inc;
                    res_reg.busy_res        <= 1'b1;
                    res_reg.ran_job         <= 6'(run_job_reg);
                    res_reg.ran_level       <= run_lv_reg;
                    res_reg.job_done        <= done_val;
                    res_reg.turnaround_time <= done_val ? 32'(tat_val) : 32'd0;
                    res_reg.response_time   <= done_val ? 32'(rsp_val) : 32'd0;
                    res_reg.wait_time       <= done_val ? 32'(job_rd_reg.wait_sum) : 32'd0;
                    if (done_val) begin
                        run_valid_reg           <= 1'b0;
                        active_reg[run_job_reg] <= 1'b0;
                    end else if (demote_val) begin
                        if (cnt_reg[next_lv] == '0) begin
                            head_reg[next_lv] <= run_job_reg;
                        end
                        tail_reg[next_lv] <= run_job_reg;
                        cnt_reg[next_lv]  <= cnt_reg[next_lv] + 1'b1;
                        run_valid_reg     <= 1'b0;
                    end
                    state_reg <= ST_OUT;
                end
                ST_OUT: begin
                    if (m_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // checks
    `TLFS_ASSERT(a_ready_excl, aclk, aresetn, !(s_ready && m_valid), "input ready while result held")
    `TLFS_ASSERT(a_top_bound, aclk, aresetn, cnt_reg[LVL_TOP] <= CW'(MAX_JOBS), "top queue overfull")
    `TLFS_ASSERT(a_result_src, aclk, aresetn, $rose(m_valid) |-> ($past(state_reg) == ST_RWR || $past(state_reg) == ST_DSP), "result without tick")
    `TLFS_ASSERT_NORST(a_reset_quiet, aclk, !aresetn |=> !m_valid, "result after reset")

endmodule
`default_nettype wire
